/* hw/rtl/jfdr_pkg.sv */
`default_nettype none

package jfdr_pkg;

  // frame geometry
  localparam int PAYLOAD_BYTES = 24;
  localparam int BANKS         = 2;
  localparam int STORE_DEPTH   = PAYLOAD_BYTES * BANKS;
  localparam int STORE_AW      = $clog2(STORE_DEPTH);
  localparam int CNT_W         = 5;
  localparam int PRE_COUNT     = 6;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] CSUM_MASK = 8'h7F;
  localparam logic [7:0] JOY_TAG   = 8'd12;

  // deframer phases
  localparam logic [2:0] PH_HUNT0 = 3'd0;
  localparam logic [2:0] PH_HUNT1 = 3'd1;
  localparam logic [2:0] PH_HUNT2 = 3'd2;
  localparam logic [2:0] PH_PAY   = 3'd3;
  localparam logic [2:0] PH_CSUM  = 3'd4;

  // configuration register indexes
  localparam int          CFG_IDX_W   = 2;
  localparam logic [1:0]  REG_VERSION = 2'd0;
  localparam logic [1:0]  REG_CONTROL = 2'd1;
  localparam logic [1:0]  REG_STATION = 2'd2;

  // output byte sources
  localparam logic [3:0] K_CONST = 4'd0;
  localparam logic [3:0] K_PAY   = 4'd1;
  localparam logic [3:0] K_HI    = 4'd2;
  localparam logic [3:0] K_LO    = 4'd3;
  localparam logic [3:0] K_SEQH  = 4'd4;
  localparam logic [3:0] K_SEQL  = 4'd5;
  localparam logic [3:0] K_VER   = 4'd6;
  localparam logic [3:0] K_CTRL  = 4'd7;
  localparam logic [3:0] K_STAT  = 4'd8;

  // section layouts
  localparam logic [1:0] SEC_HDR = 2'd0;
  localparam logic [1:0] SEC_JA  = 2'd1;  // types 0..2, fifteen bytes
  localparam logic [1:0] SEC_JB  = 2'd2;  // type 5, ten bytes
  localparam logic [1:0] SEC_JC  = 2'd3;  // other types, thirteen bytes

  // section order within a packet
  localparam logic [1:0] SECT_HDR  = 2'd0;
  localparam logic [1:0] SECT_JOY1 = 2'd1;
  localparam logic [1:0] SECT_JOY2 = 2'd2;

  // joystick field offsets in the payload
  localparam logic [4:0] JOY1_BASE = 5'd1;
  localparam logic [4:0] JOY2_BASE = 5'd13;
  localparam logic [4:0] OFF_TYPE  = 5'd2;
  localparam logic [4:0] OFF_B1    = 5'd5;
  localparam logic [4:0] OFF_B2    = 5'd8;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] val;      // constant value or payload offset
    logic       sec_end;  // last byte of its section
  } entry_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  function automatic entry_t mk_entry(input logic [3:0] kind, input logic [7:0] val,
                                      input logic sec_end);
    entry_t e;
    e.kind    = kind;
    e.val     = val;
    e.sec_end = sec_end;
    return e;
  endfunction

  function automatic logic [1:0] layout_of(input logic [7:0] jtype);
    logic [1:0] sk;
    if (jtype <= 8'd2) begin
      sk = SEC_JA;
    end else if (jtype == 8'd5) begin
      sk = SEC_JB;
    end else begin
      sk = SEC_JC;
    end
    return sk;
  endfunction

  // payload offset of the preloaded type and button bytes
  function automatic logic [4:0] pre_offset(input logic [2:0] idx);
    logic [4:0] off;
    unique case (idx)
      3'd0:    off = JOY1_BASE + OFF_TYPE;
      3'd1:    off = JOY1_BASE + OFF_B1;
      3'd2:    off = JOY1_BASE + OFF_B2;
      3'd3:    off = JOY2_BASE + OFF_TYPE;
      3'd4:    off = JOY2_BASE + OFF_B1;
      default: off = JOY2_BASE + OFF_B2;
    endcase
    return off;
  endfunction

  // packet template: source of each byte of a section
  function automatic entry_t jfdr_entry(input logic [1:0] sk, input logic [3:0] pos);
    entry_t e;
    e = mk_entry(K_CONST, 8'h00, 1'b1);
    unique case (sk)
      SEC_HDR: begin
        unique case (pos)
          4'd0:    e = mk_entry(K_SEQH, 8'd0, 1'b0);
          4'd1:    e = mk_entry(K_SEQL, 8'd0, 1'b0);
          4'd2:    e = mk_entry(K_VER,  8'd0, 1'b0);
          4'd3:    e = mk_entry(K_PAY,  8'd0, 1'b0);
          4'd4:    e = mk_entry(K_CTRL, 8'd0, 1'b0);
          default: e = mk_entry(K_STAT, 8'd0, 1'b1);
        endcase
      end
      SEC_JA: begin
        unique case (pos)
          4'd0:    e = mk_entry(K_CONST, 8'h0E, 1'b0);
          4'd1:    e = mk_entry(K_CONST, JOY_TAG, 1'b0);
          4'd2:    e = mk_entry(K_CONST, 8'd6, 1'b0);
          4'd3:    e = mk_entry(K_PAY, 8'd3, 1'b0);
          4'd4:    e = mk_entry(K_PAY, 8'd4, 1'b0);
          4'd5:    e = mk_entry(K_PAY, 8'd6, 1'b0);
          4'd6:    e = mk_entry(K_PAY, 8'd7, 1'b0);
          4'd7:    e = mk_entry(K_PAY, 8'd9, 1'b0);
          4'd8:    e = mk_entry(K_PAY, 8'd10, 1'b0);
          4'd9:    e = mk_entry(K_CONST, 8'h0A, 1'b0);
          4'd10:   e = mk_entry(K_HI, 8'd0, 1'b0);
          4'd11:   e = mk_entry(K_LO, 8'd0, 1'b0);
          4'd12:   e = mk_entry(K_CONST, 8'd1, 1'b0);
          4'd13:   e = mk_entry(K_PAY, 8'd0, 1'b0);
          default: e = mk_entry(K_PAY, 8'd1, 1'b1);
        endcase
      end
      SEC_JB: begin
        unique case (pos)
          4'd0:    e = mk_entry(K_CONST, 8'h09, 1'b0);
          4'd1:    e = mk_entry(K_CONST, JOY_TAG, 1'b0);
          4'd2:    e = mk_entry(K_CONST, 8'd3, 1'b0);
          4'd3:    e = mk_entry(K_PAY, 8'd3, 1'b0);
          4'd4:    e = mk_entry(K_PAY, 8'd4, 1'b0);
          4'd5:    e = mk_entry(K_PAY, 8'd6, 1'b0);
          4'd6:    e = mk_entry(K_CONST, 8'h0B, 1'b0);
          4'd7:    e = mk_entry(K_HI, 8'd0, 1'b0);
          4'd8:    e = mk_entry(K_LO, 8'd0, 1'b0);
          default: e = mk_entry(K_CONST, 8'd0, 1'b1);
        endcase
      end
      default: begin
        unique case (pos)
          4'd0:    e = mk_entry(K_CONST, 8'h0C, 1'b0);
          4'd1:    e = mk_entry(K_CONST, JOY_TAG, 1'b0);
          4'd2:    e = mk_entry(K_CONST, 8'd4, 1'b0);
          4'd3:    e = mk_entry(K_PAY, 8'd3, 1'b0);
          4'd4:    e = mk_entry(K_PAY, 8'd4, 1'b0);
          4'd5:    e = mk_entry(K_PAY, 8'd6, 1'b0);
          4'd6:    e = mk_entry(K_PAY, 8'd7, 1'b0);
          4'd7:    e = mk_entry(K_CONST, 8'h0C, 1'b0);
          4'd8:    e = mk_entry(K_HI, 8'd0, 1'b0);
          4'd9:    e = mk_entry(K_LO, 8'd0, 1'b0);
          4'd10:   e = mk_entry(K_CONST, 8'd1, 1'b0);
          4'd11:   e = mk_entry(K_PAY, 8'd0, 1'b0);
          default: e = mk_entry(K_PAY, 8'd1, 1'b1);
        endcase
      end
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/jfdr_if.sv */
`default_nettype none

// received byte stream
interface jfdr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// repacked packet byte stream
interface jfdr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, output tx_byte, output tx_last, input ready);
  modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/jfdr_ram.sv */
`default_nettype none

module jfdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/jfdr_queue.sv */
`default_nettype none

module jfdr_queue
  import jfdr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire logic push_bank,
  input  wire logic pop,
  output      logic empty,
  output      logic full,
  output      logic head_bank
);

  // two-entry queue of filled bank numbers
  logic [BANKS-1:0] slot_r;
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign empty     = (count_r == 2'd0);
  assign full      = (count_r == 2'd2);
  assign head_bank = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_bank;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("frame queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("frame queue underflow");

endmodule

`default_nettype wire

/* hw/rtl/jfdr_front.sv */
`default_nettype none

module jfdr_front
  import jfdr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  jfdr_rx_if.sink                  in_ch,
  input  wire release_t            rel,
  output      logic                st_we,
  output      logic [STORE_AW-1:0] st_waddr,
  output      logic [7:0]          st_wdata,
  output      logic                q_push,
  output      logic                q_bank
);

  logic [2:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             wr_bank_r;
  logic [BANKS-1:0] busy_r;
  logic             accept;
  logic             good;
  logic [2:0]       hunt;

  // payload bytes wait only while their bank is still being sent
  assign in_ch.ready = !((phase_r == PH_PAY) && busy_r[wr_bank_r]);
  assign accept      = in_ch.valid && in_ch.ready;

  assign st_we    = accept && (phase_r == PH_PAY);
  assign st_waddr = STORE_AW'(cnt_r) + (wr_bank_r ? STORE_AW'(PAYLOAD_BYTES) : '0);
  assign st_wdata = in_ch.rx_byte;

  assign good   = ((sum_r & CSUM_MASK) == in_ch.rx_byte);
  assign q_push = accept && (phase_r == PH_CSUM) && good;
  assign q_bank = wr_bank_r;

  // phases past the checksum act as hunting
  assign hunt = (phase_r > PH_CSUM) ? PH_HUNT0 : phase_r;

  // frame phase tracking
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    if (accept) begin
      unique case (phase_r)
        PH_PAY: begin
          sum_nxt = sum_r + in_ch.rx_byte;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(PAYLOAD_BYTES - 1)) begin
            phase_nxt = PH_CSUM;
          end
        end
        PH_CSUM: begin
          phase_nxt = PH_HUNT0;
        end
        default: begin
          if (in_ch.rx_byte == SYNC_BYTE) begin
            phase_nxt = hunt + 3'd1;
            sum_nxt   = 8'd0;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = PH_HUNT0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT0;
      cnt_r     <= '0;
      sum_r     <= 8'd0;
      wr_bank_r <= 1'b0;
      busy_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
      if (q_push) begin
        wr_bank_r <= ~wr_bank_r;
      end
      // a bank is busy from its good checksum until its last byte is loaded into the output register
      for (int b = 0; b < BANKS; b++) begin
        if (q_push && (wr_bank_r == 1'(b))) begin
          busy_r[b] <= 1'b1;
        end else if (rel.valid && (rel.bank == 1'(b))) begin
          busy_r[b] <= 1'b0;
        end
      end
    end
  end

  a_write_free_bank: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> !busy_r[wr_bank_r])
    else $error("payload written into a bank that is being sent");
  a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rel.valid |-> busy_r[rel.bank])
    else $error("release of a bank that was not busy");
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !busy_r[wr_bank_r])
    else $error("good frame on a busy bank");

endmodule

`default_nettype wire

/* hw/rtl/jfdr_back.sv */
`default_nettype none

module jfdr_back
  import jfdr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  input  wire logic                 q_empty,
  input  wire logic                 q_head,
  output      logic                 q_pop,
  output      logic                 st_re,
  output      logic [STORE_AW-1:0]  st_raddr,
  input  wire logic [7:0]           st_rdata,
  output      release_t             rel,
  jfdr_tx_if.source                 out_ch
);

  localparam logic [1:0] BS_IDLE = 2'd0;
  localparam logic [1:0] BS_PRE  = 2'd1;
  localparam logic [1:0] BS_EMIT = 2'd2;

  logic [1:0]  state_r;
  logic [2:0]  pre_cnt_r;
  logic        bank_r;
  logic [7:0]  pre_r [PRE_COUNT];
  logic [1:0]  sec_r;
  logic [3:0]  pos_r;
  logic [15:0] seq_r;
  logic [7:0]  version_r, control_r, station_r;

  logic [3:0]  cur_kind_r;
  logic [7:0]  cur_val_r;
  logic [1:0]  cur_sec_r;
  logic        cur_final_r;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  logic                out_free;
  logic                pre_re;
  logic                issue_en;
  logic                load_en;
  logic [1:0]          sk;
  entry_t              ent;
  logic [4:0]          base;
  logic [4:0]          abs_off;
  logic [STORE_AW-1:0] bank_off;
  logic [7:0]          b1, b2;
  logic [7:0]          byte_val;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 8'd1;
      control_r <= 8'd16;
      station_r <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VERSION: version_r <= cfg_data;
        REG_CONTROL: control_r <= cfg_data;
        REG_STATION: station_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (state_r == BS_IDLE) && !q_empty;
  assign pre_re   = (state_r == BS_PRE) && (pre_cnt_r < 3'(PRE_COUNT));
  assign issue_en = ((state_r == BS_PRE) && (pre_cnt_r == 3'(PRE_COUNT)))
                 || ((state_r == BS_EMIT) && out_free && !cur_final_r);
  assign load_en  = (state_r == BS_EMIT) && out_free;

  // template lookup for the next byte to issue
  always_comb begin
    unique case (sec_r)
      SECT_JOY1: sk = layout_of(pre_r[0]);
      SECT_JOY2: sk = layout_of(pre_r[3]);
      default:   sk = SEC_HDR;
    endcase
    unique case (sec_r)
      SECT_JOY1: base = JOY1_BASE;
      SECT_JOY2: base = JOY2_BASE;
      default:   base = 5'd0;
    endcase
  end

  assign ent      = jfdr_entry(sk, pos_r);
  assign abs_off  = base + ent.val[4:0];
  assign bank_off = bank_r ? STORE_AW'(PAYLOAD_BYTES) : '0;
  assign st_re    = pre_re || issue_en;
  assign st_raddr = pre_re ? (STORE_AW'(pre_offset(pre_cnt_r)) + bank_off)
                           : (STORE_AW'(abs_off) + bank_off);

  // compose the byte whose store read was issued last
  assign b1 = (cur_sec_r == SECT_JOY1) ? pre_r[1] : pre_r[4];
  assign b2 = (cur_sec_r == SECT_JOY1) ? pre_r[2] : pre_r[5];

  always_comb begin
    unique case (cur_kind_r)
      K_CONST: byte_val = cur_val_r;
      K_PAY:   byte_val = st_rdata;
      K_HI:    byte_val = {1'b0, b2[7:1]};
      K_LO:    byte_val = b1 | {b2[0], 7'd0};
      K_SEQH:  byte_val = seq_r[15:8];
      K_SEQL:  byte_val = seq_r[7:0];
      K_VER:   byte_val = version_r;
      K_CTRL:  byte_val = control_r;
      K_STAT:  byte_val = station_r;
      default: byte_val = 8'd0;
    endcase
  end

  assign rel.valid = load_en && cur_final_r;
  assign rel.bank  = bank_r;

  // packet sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      pre_cnt_r   <= 3'd0;
      sec_r       <= SECT_HDR;
      pos_r       <= 4'd0;
      seq_r       <= 16'd1;
      cur_final_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        BS_IDLE: begin
          if (q_pop) begin
            state_r   <= BS_PRE;
            pre_cnt_r <= 3'd0;
            sec_r     <= SECT_HDR;
            pos_r     <= 4'd0;
          end
        end
        BS_PRE: begin
          pre_cnt_r <= pre_cnt_r + 3'd1;
          if (pre_cnt_r == 3'(PRE_COUNT)) begin
            state_r <= BS_EMIT;
          end
        end
        BS_EMIT: begin
          if (load_en && cur_final_r) begin
            state_r <= BS_IDLE;
            seq_r   <= seq_r + 16'd1;
          end
        end
        default: state_r <= BS_IDLE;
      endcase

      if (issue_en) begin
        cur_final_r <= ent.sec_end && (sec_r == SECT_JOY2);
        if (ent.sec_end) begin
          sec_r <= sec_r + 2'd1;
          pos_r <= 4'd0;
        end else begin
          pos_r <= pos_r + 4'd1;
        end
      end

      if (load_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      bank_r <= q_head;
    end
    if ((state_r == BS_PRE) && (pre_cnt_r != 3'd0)) begin
      pre_r[pre_cnt_r - 3'd1] <= st_rdata;
    end
    if (issue_en) begin
      cur_kind_r <= ent.kind;
      cur_val_r  <= ent.val;
      cur_sec_r  <= sec_r;
    end
    if (load_en) begin
      out_byte_r <= byte_val;
      out_last_r <= cur_final_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.tx_byte = out_byte_r;
  assign out_ch.tx_last = out_last_r;

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == BS_EMIT)
    else $error("output loaded outside emission");
  a_seq_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(seq_r) |-> $past(rel.valid))
    else $error("sequence number moved without a finished packet");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    rel.valid |=> state_r == BS_IDLE)
    else $error("sequencer still busy after the last byte");

endmodule

`default_nettype wire

/* hw/rtl/joystick_frame_deframe_repack_unit.sv */
`default_nettype none

// Channel  Dir  Payload                       Handshake
// in_ch    in   rx_byte[7:0]                  valid/ready
// out_ch   out  tx_byte[7:0], tx_last         valid/ready
// cfg_*    in   cfg_index[1:0], cfg_data[7:0] cfg_we, no back-pressure
//
// Input bytes are accepted except that payload bytes stall only while the
// target frame bank is still being sent. A good frame is sent at one byte per
// cycle while out_ch is ready, after a queue pop and a preload of the type and
// button bytes from the frame store, 26 to 36 bytes in all. Two frame banks let
// one frame be received while the previous is sent. Synchronous reset clears
// all control state and the sequence number returns to 1; output back-pressure
// holds the output register and pauses the sender only.
module joystick_frame_deframe_repack_unit
  import jfdr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  jfdr_rx_if.sink                   in_ch,
  jfdr_tx_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  logic                st_we;
  logic [STORE_AW-1:0] st_waddr;
  logic [7:0]          st_wdata;
  logic                st_re;
  logic [STORE_AW-1:0] st_raddr;
  logic [7:0]          st_rdata;
  logic                q_push, q_bank, q_pop, q_empty, q_full, q_head;
  release_t            rel;

  // deframer and checksum check
  jfdr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .rel      (rel),
    .st_we    (st_we),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .q_push   (q_push),
    .q_bank   (q_bank)
  );

  // two banks of payload bytes
  jfdr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // good frames waiting to be sent
  jfdr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_bank (q_bank),
    .pop       (q_pop),
    .empty     (q_empty),
    .full      (q_full),
    .head_bank (q_head)
  );

  // packet builder
  jfdr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .st_re     (st_re),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata),
    .rel       (rel),
    .out_ch    (out_ch)
  );

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("good frame with both banks queued");

endmodule

`default_nettype wire

/* tb/joystick_frame_deframe_repack_unit_test.sv */
`timescale 1ns / 100ps

module joystick_frame_deframe_repack_unit_test;
  import jfdr_pkg::*;

  // run limits
  localparam int SETTLE_CYCLES = 24;    // pop plus preload, with margin
  localparam int HOLD_CYCLES   = 400;   // long output hold-off
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transaction on either side
  localparam int MID_BYTES     = 90;    // random bytes before the second register change
  localparam int RANDOM_BYTES  = 115;

  // register index the block does not decode
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // joystick section layouts
  localparam logic [7:0] TYPE_FULL_MAX = 8'd2;
  localparam logic [7:0] TYPE_SHORT    = 8'd5;
  localparam logic [7:0] HDR_FULL      = 8'h0E;
  localparam logic [7:0] AXES_FULL     = 8'd6;
  localparam logic [7:0] BTN_FULL      = 8'h0A;
  localparam logic [7:0] HDR_SHORT     = 8'h09;
  localparam logic [7:0] AXES_SHORT    = 8'd3;
  localparam logic [7:0] BTN_SHORT     = 8'h0B;
  localparam logic [7:0] HDR_MID       = 8'h0C;
  localparam logic [7:0] AXES_MID      = 8'd4;
  localparam logic [7:0] BTN_MID       = 8'h0C;
  localparam logic [7:0] TRAIL_ON      = 8'd1;
  localparam logic [7:0] TRAIL_OFF     = 8'd0;

  typedef enum logic [1:0] {LEAD_NONE, LEAD_NOISE, LEAD_BROKEN} lead_t;
  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RAND} fill_t;
  typedef enum logic [1:0] {CS_GOOD, CS_BAD, CS_HIGH} csum_t;
  typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_MOSTLY, SINK_PATTERN} sink_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  // one directed frame; header and length typed in where obvious
  typedef struct packed {
    logic        cfg_on;
    logic [7:0]  ver;
    logic [7:0]  ctl;
    logic [7:0]  sta;
    lead_t       lead;
    fill_t       fill;
    logic [7:0]  type1;
    logic [7:0]  type2;
    csum_t       csum;
    logic        typed;
    logic [5:0]  exp_len;
    logic [47:0] exp_hdr;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  jfdr_rx_if in_ch ();
  jfdr_tx_if out_ch ();

  joystick_frame_deframe_repack_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // deframer/repacker state as the testbench sees it
  logic [2:0]  hunt_phase  = PH_HUNT0;
  logic [4:0]  pay_idx     = '0;
  logic [7:0]  pay_sum     = '0;
  logic [7:0]  pay_store [PAYLOAD_BYTES];
  logic [15:0] next_seq    = 16'd1;
  logic [7:0]  reg_version = 8'd1;
  logic [7:0]  reg_control = 8'd16;
  logic [7:0]  reg_station = 8'd0;

  pkt_byte_t   packet_bytes_due [$];
  logic [7:0]  open_pkt [$];
  logic [7:0]  seen_pkt [$];
  int          pkts_seen   = 0;
  int          mismatches  = 0;
  int          quiet_cycles = 0;
  int          rx_sent     = 0;
  int          burst_left  = 0;
  bit          gapless     = 1'b0;
  bit          hold_req    = 1'b0;

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $time);
  endtask

  task automatic put_byte(input logic [7:0] b);
    packet_bytes_due.push_back({b, 1'b0});
  endtask

  // one joystick section; button bit 0 of B2 moves to bit 7 of lo
  task automatic put_joystick(input int base);
    logic [7:0] ty;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] hi;
    logic [7:0] lo;
    ty = pay_store[base + 2];
    b1 = pay_store[base + 5];
    b2 = pay_store[base + 8];
    hi = b2 >> 1;
    lo = b1 | {b2[0], 7'd0};
    if (ty <= TYPE_FULL_MAX) begin
      put_byte(HDR_FULL); put_byte(JOY_TAG); put_byte(AXES_FULL);
      put_byte(pay_store[base + 3]); put_byte(pay_store[base + 4]);
      put_byte(pay_store[base + 6]); put_byte(pay_store[base + 7]);
      put_byte(pay_store[base + 9]); put_byte(pay_store[base + 10]);
      put_byte(BTN_FULL); put_byte(hi); put_byte(lo); put_byte(TRAIL_ON);
      put_byte(pay_store[base]); put_byte(pay_store[base + 1]);
    end else if (ty == TYPE_SHORT) begin
      put_byte(HDR_SHORT); put_byte(JOY_TAG); put_byte(AXES_SHORT);
      put_byte(pay_store[base + 3]); put_byte(pay_store[base + 4]);
      put_byte(pay_store[base + 6]);
      put_byte(BTN_SHORT); put_byte(hi); put_byte(lo); put_byte(TRAIL_OFF);
    end else begin
      put_byte(HDR_MID); put_byte(JOY_TAG); put_byte(AXES_MID);
      put_byte(pay_store[base + 3]); put_byte(pay_store[base + 4]);
      put_byte(pay_store[base + 6]); put_byte(pay_store[base + 7]);
      put_byte(BTN_MID); put_byte(hi); put_byte(lo); put_byte(TRAIL_ON);
      put_byte(pay_store[base]); put_byte(pay_store[base + 1]);
    end
  endtask

  // advance the deframer by one received byte, queue any packet it completes
  task automatic deframe_byte(input logic [7:0] rx);
    if (hunt_phase == PH_PAY) begin
      if (pay_idx < PAYLOAD_BYTES)
        pay_store[pay_idx] = rx;
      pay_sum = pay_sum + rx;
      pay_idx = pay_idx + 5'd1;
      if (pay_idx >= PAYLOAD_BYTES)
        hunt_phase = PH_CSUM;
    end else if (hunt_phase == PH_CSUM) begin
      hunt_phase = PH_HUNT0;
      if ((pay_sum & CSUM_MASK) == rx) begin
        put_byte(next_seq[15:8]);
        put_byte(next_seq[7:0]);
        put_byte(reg_version);
        put_byte(pay_store[0]);
        put_byte(reg_control);
        put_byte(reg_station);
        next_seq = next_seq + 16'd1;
        put_joystick(JOY1_BASE);
        put_joystick(JOY2_BASE);
        packet_bytes_due[packet_bytes_due.size() - 1].last = 1'b1;
      end
    end else begin
      if (hunt_phase > PH_CSUM)
        hunt_phase = PH_HUNT0;
      if (rx == SYNC_BYTE) begin
        hunt_phase = hunt_phase + 3'd1;
        pay_sum    = '0;
        pay_idx    = '0;
      end else begin
        hunt_phase = PH_HUNT0;
      end
    end
  endtask

  task automatic check_tx(input logic [7:0] b, input logic last);
    pkt_byte_t want;
    if (packet_bytes_due.size() == 0) begin
      report("tx_byte with nothing due", b, 0);
    end else begin
      want = packet_bytes_due.pop_front();
      if (b !== want.data)
        report("tx_byte", b, want.data);
      if (last !== want.last)
        report("tx_last", last, want.last);
    end
    open_pkt.push_back(b);
    if (last === 1'b1) begin
      seen_pkt = open_pkt;
      open_pkt.delete();
      pkts_seen++;
    end
  endtask

  // monitors, prediction and the watchdog
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      check_tx(out_ch.tx_byte, out_ch.tx_last);
    if (rst_n && in_ch.valid && in_ch.ready)
      deframe_byte(in_ch.rx_byte);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall modes, plus a long hold-off on request
  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_left = 0;
  logic [7:0] sink_pat  = 8'hA5;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (sink_left == 0) begin
          sink_mode = sink_mode_t'($urandom_range(0, 3));
          sink_left = $urandom_range(20, 80);
          sink_pat  = 8'($urandom) | 8'h01;
        end
        sink_left--;
        sink_pat = {sink_pat[6:0], sink_pat[7]};
        case (sink_mode)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
          SINK_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:     out_ch.ready <= sink_pat[0];
        endcase
      end
    end
  end

  // sender: one transaction, in bursts separated by random gaps unless gapless is set
  task automatic push_rx(input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!gapless) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rx_sent++;
  endtask

  // stop sending and wait for every due packet byte, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (packet_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_VERSION: reg_version = val;
      REG_CONTROL: reg_control = val;
      REG_STATION: reg_station = val;
      default: ;
    endcase
  endtask

  // only called with the block idle
  task automatic set_regs(input logic [7:0] ver, input logic [7:0] ctl,
                          input logic [7:0] sta);
    write_reg(REG_VERSION, ver);
    write_reg(REG_CONTROL, ctl);
    write_reg(REG_STATION, sta);
    write_reg(REG_UNUSED, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8)
      return 8'(r);
    return 8'($urandom);
  endfunction

  task automatic send_frame(input lead_t lead, input fill_t fill, input logic [7:0] type1,
                            input logic [7:0] type2, input csum_t csum);
    logic [7:0] pay [PAYLOAD_BYTES];
    logic [7:0] sum;
    int         i;
    // leading junk: plain noise, or sync runs that break before the third
    if (lead == LEAD_NOISE) begin
      repeat ($urandom_range(1, 4)) push_rx(8'($urandom_range(0, 254)));
    end else if (lead == LEAD_BROKEN) begin
      push_rx(SYNC_BYTE);
      push_rx(SYNC_BYTE);
      push_rx(8'($urandom_range(0, 254)));
      push_rx(SYNC_BYTE);
      push_rx(8'($urandom_range(0, 254)));
    end
    repeat (3) push_rx(SYNC_BYTE);
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      case (fill)
        FILL_ZERO: pay[i] = 8'h00;
        FILL_ONES: pay[i] = 8'hFF;
        default:   pay[i] = 8'($urandom);
      endcase
    end
    pay[JOY1_BASE + OFF_TYPE] = type1;
    pay[JOY2_BASE + OFF_TYPE] = type2;
    sum = '0;
    for (i = 0; i < PAYLOAD_BYTES; i++) begin
      sum = sum + pay[i];
      push_rx(pay[i]);
    end
    case (csum)
      CS_GOOD: push_rx(sum & CSUM_MASK);
      CS_BAD:  push_rx((sum + 8'($urandom_range(1, 127))) & CSUM_MASK);
      default: push_rx((sum & CSUM_MASK) | 8'h80);
    endcase
  endtask

  task automatic random_frame(input bit clean);
    lead_t lead;
    csum_t csum;
    int    r;
    lead = LEAD_NONE;
    csum = CS_GOOD;
    if (!clean) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        lead = LEAD_NOISE;
      else if (r < 14)
        lead = LEAD_BROKEN;
      r = $urandom_range(0, 99);
      if (r < 10)
        csum = CS_BAD;
      else if (r < 15)
        csum = CS_HIGH;
    end
    send_frame(lead, FILL_RAND, pick_type(), pick_type(), csum);
  endtask

  // mostly well-formed frames; some loose noise and cut-off frames
  task automatic random_traffic(input int until_sent);
    int r;
    while (rx_sent < until_sent) begin
      if ($urandom_range(0, 4) == 0)
        gapless = ~gapless;
      r = $urandom_range(0, 99);
      if (r < 78) begin
        random_frame(1'b0);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 6))
          push_rx(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom_range(0, 254)));
      end else begin
        repeat (3) push_rx(SYNC_BYTE);
        repeat ($urandom_range(0, PAYLOAD_BYTES - 1)) push_rx(8'($urandom));
      end
    end
    gapless = 1'b0;
  endtask

  plan_row_t plan [7];

  initial begin
    int r;
    int h;
    int pkts_before;
    int rand_base;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_VERSION;
    cfg_data      = 8'h00;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;

    plan = '{
      '{1'b0, 8'h00, 8'h00, 8'h00, LEAD_NONE, FILL_ZERO, 8'h00, 8'h00, CS_GOOD,
        1'b1, 6'd36, 48'h0001_0100_1000},
      '{1'b0, 8'h00, 8'h00, 8'h00, LEAD_NONE, FILL_ONES, 8'hFF, 8'hFF, CS_GOOD,
        1'b1, 6'd32, 48'h0002_01FF_1000},
      '{1'b0, 8'h00, 8'h00, 8'h00, LEAD_NONE, FILL_ZERO, 8'h05, 8'h05, CS_GOOD,
        1'b1, 6'd26, 48'h0003_0100_1000},
      '{1'b0, 8'h00, 8'h00, 8'h00, LEAD_NONE, FILL_RAND, 8'h02, 8'h03, CS_BAD,
        1'b1, 6'd0, 48'h0},
      '{1'b0, 8'h00, 8'h00, 8'h00, LEAD_NONE, FILL_RAND, 8'h05, 8'h00, CS_HIGH,
        1'b1, 6'd0, 48'h0},
      '{1'b0, 8'h00, 8'h00, 8'h00, LEAD_BROKEN, FILL_RAND, 8'h01, 8'h02, CS_GOOD,
        1'b0, 6'd0, 48'h0},
      '{1'b1, 8'hFF, 8'hFF, 8'hFF, LEAD_NONE, FILL_ZERO, 8'h00, 8'h00, CS_GOOD,
        1'b1, 6'd36, 48'h0005_FF00_FFFF}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames, block drained after each
    for (r = 0; r < $size(plan); r++) begin
      if (plan[r].cfg_on)
        set_regs(plan[r].ver, plan[r].ctl, plan[r].sta);
      pkts_before = pkts_seen;
      send_frame(plan[r].lead, plan[r].fill, plan[r].type1, plan[r].type2, plan[r].csum);
      drain();
      if (plan[r].typed) begin
        if (plan[r].exp_len == 0) begin
          if (pkts_seen != pkts_before)
            report("packets from a dropped frame", pkts_seen - pkts_before, 0);
        end else if (pkts_seen != pkts_before + 1) begin
          report("packets from a good frame", pkts_seen - pkts_before, 1);
        end else begin
          if (seen_pkt.size() != plan[r].exp_len)
            report("packet length", seen_pkt.size(), plan[r].exp_len);
          for (h = 0; h < 6 && h < seen_pkt.size(); h++)
            if (seen_pkt[h] !== plan[r].exp_hdr[47 - 8 * h -: 8])
              report("header byte", seen_pkt[h], plan[r].exp_hdr[47 - 8 * h -: 8]);
        end
      end
    end

    // random traffic with register changes between phases
    rand_base = rx_sent;
    set_regs(8'($urandom), 8'($urandom), 8'($urandom));

    // output held off while clean frames keep coming: both banks fill, input stalls
    hold_req = 1'b1;
    gapless  = 1'b1;
    repeat (3) random_frame(1'b1);
    gapless  = 1'b0;

    random_traffic(rand_base + MID_BYTES);
    drain();
    set_regs(8'hFF, 8'h00, 8'($urandom));
    random_traffic(rand_base + RANDOM_BYTES);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (packet_bytes_due.size() != 0)
      report("packet bytes still due", packet_bytes_due.size(), 0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
